// ----- rtl/uartrx_pkg.sv -----
// shared types and constants for the uart receive idle timeout framer
package uartrx_pkg;

    // frame length limit accepted by an arm transfer
    localparam int MAX_FRAME_LEN = 65535;

    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int IDLE_W   = 24;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic [IDLE_W-1:0] IDLE_RESET = IDLE_W'(1000);
    localparam logic [IDLE_W-1:0] IDLE_SAT   = {IDLE_W{1'b1}};

    // item kinds carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABORT = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              parity_error;
        logic              frame_error;
        logic [LEN_W-1:0]  max_length;
    } item_t;

    typedef struct packed {
        logic              arm_accepted;
        logic              byte_valid;
        logic [BYTE_W-1:0] byte_value;
        logic [LEN_W-1:0]  byte_index;
        logic              done_res;
        logic [LEN_W-1:0]  done_length;
    } result_t;

endpackage

// ----- rtl/uartrx_core.sv -----
// frame state registers and the per-item update and result logic
module uartrx_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  uartrx_pkg::item_t                   item,
    input  logic                                cfg_wr_en,
    input  logic [uartrx_pkg::IDLE_W-1:0]       cfg_wr_data,
    output uartrx_pkg::result_t                 result
);

    logic                          active_reg, active_next;
    logic [uartrx_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [uartrx_pkg::LEN_W-1:0]  limit_reg, limit_next;
    logic [uartrx_pkg::IDLE_W-1:0] idle_reg, idle_next;
    logic [uartrx_pkg::IDLE_W-1:0] timeout_reg;

    logic                          good_byte;
    logic [uartrx_pkg::LEN_W-1:0]  count_upd;
    logic [uartrx_pkg::IDLE_W-1:0] idle_upd;
    logic                          arm_ok;

    // count and idle values after a tick
    assign good_byte = item.rx_valid && !item.parity_error && !item.frame_error;
    assign count_upd = good_byte ? count_reg + 1'b1 : count_reg;
    assign idle_upd  = good_byte ? '0 :
                       (idle_reg == uartrx_pkg::IDLE_SAT) ? idle_reg : idle_reg + 1'b1;
    assign arm_ok    = !active_reg && (item.max_length != '0)
                       && (32'(item.max_length) <= uartrx_pkg::MAX_FRAME_LEN);

    // next state and result for the item at the input
    always_comb begin
        active_next = active_reg;
        count_next  = count_reg;
        limit_next  = limit_reg;
        idle_next   = idle_reg;
        result      = '0;
        case (item.mode)
            uartrx_pkg::MODE_ARM: begin
                if (arm_ok) begin
                    active_next         = 1'b1;
                    count_next          = '0;
                    limit_next          = item.max_length;
                    idle_next           = '0;
                    result.arm_accepted = 1'b1;
                end
            end
            uartrx_pkg::MODE_ABORT: begin
                if (active_reg) begin
                    result.done_res    = 1'b1;
                    result.done_length = count_reg;
                end
                active_next = 1'b0;
                count_next  = '0;
                idle_next   = '0;
            end
            uartrx_pkg::MODE_TICK: begin
                if (active_reg) begin
                    result.byte_valid = good_byte;
                    result.byte_value = good_byte ? item.rx_byte : '0;
                    result.byte_index = good_byte ? count_reg : '0;
                    count_next        = count_upd;
                    idle_next         = idle_upd;
                    // completion by length, or by idle line once a byte is in
                    if ((count_upd >= limit_reg)
                        || ((count_upd != '0) && (idle_upd >= timeout_reg))) begin
                        result.done_res    = 1'b1;
                        result.done_length = count_upd;
                        active_next        = 1'b0;
                        count_next         = '0;
                        idle_next          = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // frame state, updated on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            limit_reg  <= '0;
            idle_reg   <= '0;
        end else if (step) begin
            active_reg <= active_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            idle_reg   <= idle_next;
        end
    end

    // idle timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= uartrx_pkg::IDLE_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

endmodule

// ----- rtl/uart_rx_idle_timeout_framer_unit.sv -----
// top level of the uart receive framer with idle line timeout
// the result of an input transfer is registered and shown on the m_ side in the cycle after it
// throughput: one item per cycle while the m_ side takes results; the output register frees as it is taken
// every input transfer gives exactly one result transfer
// reset (aresetn low, synchronous): frame idle, counters and limit cleared,
// idle timeout back to 1000 ticks, output register empty
module uart_rx_idle_timeout_framer_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // slave side
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // rx_valid, rx_byte, parity_error, frame_error, max_length, zero pad
    input  logic [uartrx_pkg::S_DATA_W-1:0]       s_tdata,
    // mode
    input  logic [uartrx_pkg::MODE_W-1:0]         s_tuser,
    // master side
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // byte_value, byte_index, done_length
    output logic [uartrx_pkg::M_DATA_W-1:0]       m_tdata,
    // arm_accepted, byte_valid
    output logic [1:0]                            m_tuser,
    // done_res
    output logic                                  m_tlast,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [uartrx_pkg::IDLE_W-1:0]         cfg_wr_data
);

    uartrx_pkg::item_t   item;
    uartrx_pkg::result_t result;
    uartrx_pkg::result_t out_reg;
    logic                out_valid_reg;
    logic                step;

    // unpack the input transfer
    always_comb begin
        item.mode         = s_tuser;
        item.rx_valid     = s_tdata[0];
        item.rx_byte      = s_tdata[8:1];
        item.parity_error = s_tdata[9];
        item.frame_error  = s_tdata[10];
        item.max_length   = s_tdata[26:11];
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    uartrx_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.done_length, out_reg.byte_index, out_reg.byte_value};
    assign m_tuser  = {out_reg.byte_valid, out_reg.arm_accepted};
    assign m_tlast  = out_reg.done_res;

endmodule

// ----- bench/uart_rx_idle_timeout_framer_unit_test.sv -----
// testbench for the uart receive framer: queued stimulus, predicted results, stream checks
`timescale 1ns / 100ps

module uart_rx_idle_timeout_framer_unit_test;

    // mode code left unused by the block
    localparam logic [uartrx_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;
    localparam int HOLD_AT     = 300;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [uartrx_pkg::S_DATA_W-1:0] s_tdata     = '0;
    logic [uartrx_pkg::MODE_W-1:0]   s_tuser     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [uartrx_pkg::M_DATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_wr_en   = 1'b0;
    logic [uartrx_pkg::IDLE_W-1:0]   cfg_wr_data = '0;

    // items waiting to be sent and results predicted for accepted items
    uartrx_pkg::item_t   uart_items[$];
    uartrx_pkg::result_t predicted_results[$];
    uartrx_pkg::item_t   in_flight;

    // predicted framer state
    logic                          frame_open   = 1'b0;
    logic [uartrx_pkg::LEN_W-1:0]  stored_count = '0;
    logic [uartrx_pkg::LEN_W-1:0]  frame_limit  = '0;
    logic [uartrx_pkg::IDLE_W-1:0] idle_ticks   = '0;
    logic [uartrx_pkg::IDLE_W-1:0] idle_timeout = uartrx_pkg::IDLE_RESET;

    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int items_queued  = 0;
    int results_seen  = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;

    uart_rx_idle_timeout_framer_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // advance the framer by one item and give the result it reports
    function automatic uartrx_pkg::result_t frame_step(uartrx_pkg::item_t it);
        uartrx_pkg::result_t r;
        logic                close;
        r     = '0;
        close = 1'b0;
        case (it.mode)
            uartrx_pkg::MODE_ARM: begin
                if (!frame_open && it.max_length != '0) begin
                    frame_open     = 1'b1;
                    stored_count   = '0;
                    frame_limit    = it.max_length;
                    idle_ticks     = '0;
                    r.arm_accepted = 1'b1;
                end
            end
            uartrx_pkg::MODE_ABORT: begin
                if (frame_open) begin
                    close = 1'b1;
                end else begin
                    stored_count = '0;
                    idle_ticks   = '0;
                end
            end
            uartrx_pkg::MODE_TICK: begin
                if (frame_open) begin
                    if (it.rx_valid && !it.parity_error && !it.frame_error) begin
                        r.byte_valid = 1'b1;
                        r.byte_value = it.rx_byte;
                        r.byte_index = stored_count;
                        stored_count = stored_count + 1'b1;
                        idle_ticks   = '0;
                    end else if (idle_ticks != uartrx_pkg::IDLE_SAT) begin
                        idle_ticks = idle_ticks + 1'b1;
                    end
                    if (stored_count >= frame_limit)
                        close = 1'b1;
                    else if (stored_count != '0 && idle_ticks >= idle_timeout)
                        close = 1'b1;
                end
            end
            default: ;
        endcase
        if (close) begin
            r.done_res    = 1'b1;
            r.done_length = stored_count;
            frame_open    = 1'b0;
            stored_count  = '0;
            idle_ticks    = '0;
        end
        return r;
    endfunction

    // item with every field random, then the mode forced
    function automatic uartrx_pkg::item_t any_item(logic [uartrx_pkg::MODE_W-1:0] mode);
        logic [31:0]       rnd;
        uartrx_pkg::item_t it;
        rnd     = $urandom;
        it      = rnd[$bits(uartrx_pkg::item_t)-1:0];
        it.mode = mode;
        return it;
    endfunction

    task automatic put(uartrx_pkg::item_t it);
        uart_items.push_back(it);
        items_queued++;
    endtask

    task automatic put_byte(logic [uartrx_pkg::BYTE_W-1:0] value);
        uartrx_pkg::item_t it;
        it              = any_item(uartrx_pkg::MODE_TICK);
        it.rx_valid     = 1'b1;
        it.rx_byte      = value;
        it.parity_error = 1'b0;
        it.frame_error  = 1'b0;
        put(it);
    endtask

    task automatic put_bad_byte(logic [1:0] errs);
        uartrx_pkg::item_t it;
        it          = any_item(uartrx_pkg::MODE_TICK);
        it.rx_valid = 1'b1;
        {it.parity_error, it.frame_error} = errs;
        put(it);
    endtask

    task automatic put_idle();
        uartrx_pkg::item_t it;
        it          = any_item(uartrx_pkg::MODE_TICK);
        it.rx_valid = 1'b0;
        put(it);
    endtask

    task automatic put_arm(logic [uartrx_pkg::LEN_W-1:0] len);
        uartrx_pkg::item_t it;
        it            = any_item(uartrx_pkg::MODE_ARM);
        it.max_length = len;
        put(it);
    endtask

    // mostly armed frames with random content, some noise; idle_run 0 means no idle bursts
    task automatic queue_traffic(int n_items, int idle_run);
        int target;
        int len;
        int r;
        int k;
        int j;
        target = items_queued + n_items;
        while (items_queued < target) begin
            r = $urandom_range(99);
            if (r < 8) begin
                put(any_item(2'($urandom_range(3))));
            end else begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(65535);
                else
                    len = $urandom_range(1, 12);
                put_arm(16'(len));
                for (k = 0; k < len + 2 && k < 40; k++) begin
                    r = $urandom_range(99);
                    if (r < 65)
                        put_byte(8'($urandom));
                    else if (r < 75)
                        put_bad_byte(2'($urandom_range(1, 3)));
                    else if (r < 88)
                        put_idle();
                    else if (r < 92)
                        put(any_item(uartrx_pkg::MODE_ABORT));
                    else if (r < 95)
                        put_arm(16'($urandom));
                    else if (idle_run > 0)
                        for (j = 0; j < idle_run; j++)
                            put_idle();
                    else
                        put_idle();
                end
            end
        end
    endtask

    // wait until no transfer is pending or outstanding
    task automatic wait_drained();
        while (uart_items.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timeout(logic [uartrx_pkg::IDLE_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        idle_timeout  = value;
        @(negedge aclk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // input driver: predict on each accepted transfer, then offer the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(frame_step(in_flight));
            if (!s_tvalid || s_tready) begin
                if (uart_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_flight = uart_items.pop_front();
                    s_tdata  <= {5'b0, in_flight.max_length, in_flight.frame_error,
                                 in_flight.parity_error, in_flight.rx_byte,
                                 in_flight.rx_valid};
                    s_tuser  <= in_flight.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back pressure and one long hold-off
    always @(posedge aclk) begin : monitor
        uartrx_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result transfer expected none actual %h %b %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("arm_accepted", want.arm_accepted, m_tuser[0]);
                    check_field("byte_valid", want.byte_valid, m_tuser[1]);
                    check_field("byte_value", want.byte_value, m_tdata[7:0]);
                    check_field("byte_index", want.byte_index, m_tdata[23:8]);
                    check_field("done_res", want.done_res, m_tlast);
                    check_field("done_length", want.done_length, m_tdata[39:24]);
                end
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // phase sequencer
    initial begin
        int k;
        send_gap_pct = 30;
        recv_gap_pct = 54;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed checks at the reset timeout
        put_byte(8'h5A);
        put(any_item(MODE_SPARE));
        put(any_item(uartrx_pkg::MODE_ABORT));
        put_arm(16'd0);
        put_arm(16'hFFFF);
        put_arm(16'd3);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_bad_byte(2'b10);
        put_bad_byte(2'b01);
        put_bad_byte(2'b11);
        put_idle();
        put(any_item(uartrx_pkg::MODE_ABORT));
        put_arm(16'd1);
        put_byte(8'hA5);
        wait_drained();

        // zero timeout: every stored byte closes the frame
        set_timeout(24'd0);
        put_arm(16'd5);
        put_bad_byte(2'b10);
        put_byte(8'h3C);
        queue_traffic(400, 1);
        wait_drained();

        // short timeout, idling swapped
        send_gap_pct = 54;
        recv_gap_pct = 30;
        set_timeout(24'd3);
        put_arm(16'd4);
        put_byte(8'hC3);
        put_idle();
        put_idle();
        put_idle();
        queue_traffic(500, 4);
        wait_drained();

        set_timeout(24'($urandom_range(1, 6)));
        queue_traffic(500, int'(idle_timeout) + 1);
        wait_drained();

        // largest timeout, no idling, one frame closed by its length
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_timeout(uartrx_pkg::IDLE_SAT);
        put(any_item(uartrx_pkg::MODE_ABORT));
        put_arm(16'd200);
        for (k = 0; k < 200; k++)
            put_byte(8'($urandom));
        queue_traffic(150, 0);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
